// File: rtl/clipped_pattern_rect_fill_assert.svh
// Assertion macros shared by the checker of the clipped pattern rectangle fill block.
`ifndef CLIPPED_PATTERN_RECT_FILL_ASSERT_SVH
`define CLIPPED_PATTERN_RECT_FILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPRF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fill engine check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CPRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fill engine check failed one cycle later");

`endif

// File: rtl/cprf_pkg.sv
// Types and constants of the clipped pattern rectangle fill engine.
`default_nettype none
package cprf_pkg;

   // Fixed field widths
   localparam int PITCH_BITS     = 13;
   localparam int COLOR_BITS     = 16;
   localparam int PATTERN_BITS   = 64;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PAT_SIDE_BITS  = 3;   // the pattern is 8 by 8 cells

   // Reset values of the registers
   localparam int PITCH_RESET       = 640;
   localparam int CLIP_RIGHT_RESET  = 640;
   localparam int CLIP_BOTTOM_RESET = 480;

   // Commands carried by a request transaction
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register indices of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_PIXELS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_LEFT    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_TOP     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_RIGHT   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_BOTTOM  = 3'd5;

   // Status codes of a response transaction
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_IDLE_STEP = 2'd2
   } status_type;

endpackage
`default_nettype wire

// File: rtl/clipped_pattern_rect_fill.sv
// An accepted request transaction passes from the input register to the result register, which presents its response.
// Throughput: one request per cycle while rsp_stall is low; the input register and the result register
// let a new request enter while a finished response waits on rsp_stall.
// The start address (clip, one multiply of the clipped top row by the pitch, add)
// is formed in the single stage.
// Reset is synchronous and active high: the engine goes idle, both stages empty,
// and the configuration registers take their reset values.
`default_nettype none
module clipped_pattern_rect_fill #(
   parameter int COORD_BITS = 16,
   parameter int ADDR_BITS  = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Configuration port
   input  wire logic                                  csr_write_enable,
   input  wire logic [cprf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [((ADDR_BITS > COORD_BITS) ?
                       ((ADDR_BITS > cprf_pkg::PITCH_BITS) ? ADDR_BITS : cprf_pkg::PITCH_BITS) :
                       ((COORD_BITS > cprf_pkg::PITCH_BITS) ? COORD_BITS :
                        cprf_pkg::PITCH_BITS))-1:0]   csr_write_data,
   // Request channel
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_command,
   input  wire logic signed [COORD_BITS-1:0]          req_area_left,
   input  wire logic signed [COORD_BITS-1:0]          req_area_top,
   input  wire logic signed [COORD_BITS-1:0]          req_area_right,
   input  wire logic signed [COORD_BITS-1:0]          req_area_bottom,
   input  wire logic [cprf_pkg::PATTERN_BITS-1:0]     req_pattern_bits,
   input  wire logic [cprf_pkg::COLOR_BITS-1:0]       req_fill_color,
   // Response channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [cprf_pkg::STATUS_BITS-1:0]      rsp_status,
   output      logic                                  rsp_write_enable,
   output      logic [ADDR_BITS-1:0]                  rsp_pixel_address,
   output      logic [cprf_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output      logic                                  rsp_last_pixel
);

   // Coordinates widened by one bit so that an exclusive bound minus one still fits
   localparam int EXT_BITS  = COORD_BITS + 1;
   localparam int WIDE_BITS = (EXT_BITS > ADDR_BITS) ? EXT_BITS : ADDR_BITS;

   // Configuration registers
   logic [ADDR_BITS-1:0]              frame_base_ff,   frame_base_in;
   logic [cprf_pkg::PITCH_BITS-1:0]   pitch_ff,        pitch_in;
   logic signed [COORD_BITS-1:0]      clip_left_ff,    clip_left_in;
   logic signed [COORD_BITS-1:0]      clip_top_ff,     clip_top_in;
   logic signed [COORD_BITS-1:0]      clip_right_ff,   clip_right_in;
   logic signed [COORD_BITS-1:0]      clip_bottom_ff,  clip_bottom_in;

   // Input register
   logic                              in_valid_ff,     in_valid_in;
   logic                              in_command_ff;
   logic signed [COORD_BITS-1:0]      in_left_ff;
   logic signed [COORD_BITS-1:0]      in_top_ff;
   logic signed [COORD_BITS-1:0]      in_right_ff;
   logic signed [COORD_BITS-1:0]      in_bottom_ff;
   logic [cprf_pkg::PATTERN_BITS-1:0] in_pattern_ff;
   logic [cprf_pkg::COLOR_BITS-1:0]   in_color_ff;

   // Engine state
   logic                              active_ff,       active_in;
   logic [ADDR_BITS-1:0]              line_address_ff, line_address_in;
   logic [COORD_BITS-1:0]             column_ff,       column_in;
   logic [COORD_BITS-1:0]             span_width_ff,   span_width_in;
   logic [COORD_BITS-1:0]             rows_left_ff,    rows_left_in;
   logic [cprf_pkg::PAT_SIDE_BITS-1:0] pattern_row_ff, pattern_row_in;
   logic [cprf_pkg::PATTERN_BITS-1:0] held_pattern_ff, held_pattern_in;
   logic [cprf_pkg::COLOR_BITS-1:0]   held_color_ff,   held_color_in;

   // Result register
   logic                              out_valid_ff,    out_valid_in;
   cprf_pkg::status_type              out_status_ff,   out_status_in;
   logic                              out_we_ff,       out_we_in;
   logic [ADDR_BITS-1:0]              out_address_ff,  out_address_in;
   logic [cprf_pkg::COLOR_BITS-1:0]   out_color_ff,    out_color_in;
   logic                              out_last_ff,     out_last_in;

   // Handshake and clip datapath
   logic                              req_accept;
   logic                              advance;
   logic signed [EXT_BITS-1:0]        area_l, area_t, area_r, area_b;
   logic signed [EXT_BITS-1:0]        bound_l, bound_t, bound_r, bound_b;
   logic signed [EXT_BITS-1:0]        clip_l, clip_t, clip_r, clip_b;
   logic signed [WIDE_BITS-1:0]       top_wide, left_wide;
   logic signed [EXT_BITS-1:0]        span_ext, rows_ext;
   logic [ADDR_BITS-1:0]              row_offset;
   logic [ADDR_BITS-1:0]              first_address;
   logic                              clip_empty;
   logic [cprf_pkg::PAT_SIDE_BITS*2-1:0] pattern_index;
   logic                              end_of_line;

   // Handshake: the input register moves on whenever the result register is free or its response is taken
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      frame_base_in  = frame_base_ff;
      pitch_in       = pitch_ff;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_right_in  = clip_right_ff;
      clip_bottom_in = clip_bottom_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cprf_pkg::CSR_FRAME_BASE:   frame_base_in  = csr_write_data[ADDR_BITS-1:0];
            cprf_pkg::CSR_PITCH_PIXELS: pitch_in       = csr_write_data[cprf_pkg::PITCH_BITS-1:0];
            cprf_pkg::CSR_CLIP_LEFT:    clip_left_in   = csr_write_data[COORD_BITS-1:0];
            cprf_pkg::CSR_CLIP_TOP:     clip_top_in    = csr_write_data[COORD_BITS-1:0];
            cprf_pkg::CSR_CLIP_RIGHT:   clip_right_in  = csr_write_data[COORD_BITS-1:0];
            cprf_pkg::CSR_CLIP_BOTTOM:  clip_bottom_in = csr_write_data[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clip the requested area; right and bottom bounds become inclusive
   always_comb begin
      area_l  = EXT_BITS'(in_left_ff);
      area_t  = EXT_BITS'(in_top_ff);
      area_r  = EXT_BITS'(in_right_ff);
      area_b  = EXT_BITS'(in_bottom_ff);
      bound_l = EXT_BITS'(clip_left_ff);
      bound_t = EXT_BITS'(clip_top_ff);
      bound_r = EXT_BITS'(clip_right_ff) - EXT_BITS'(1);
      bound_b = EXT_BITS'(clip_bottom_ff) - EXT_BITS'(1);
      clip_l  = (bound_l > area_l) ? bound_l : area_l;
      clip_t  = (bound_t > area_t) ? bound_t : area_t;
      clip_r  = (bound_r < area_r) ? bound_r : area_r;
      clip_b  = (bound_b < area_b) ? bound_b : area_b;
      clip_empty = (clip_r < clip_l) || (clip_b < clip_t);
      span_ext   = clip_r - clip_l;
      rows_ext   = clip_b - clip_t;
   end

   // Address of the clipped top-left pixel, wrapping at the address width
   always_comb begin
      top_wide      = WIDE_BITS'(clip_t);
      left_wide     = WIDE_BITS'(clip_l);
      row_offset    = top_wide[ADDR_BITS-1:0] * ADDR_BITS'(pitch_ff);
      first_address = frame_base_ff + row_offset + left_wide[ADDR_BITS-1:0];
   end

   // Pattern cell of the current pixel and end of its line
   assign pattern_index = {pattern_row_ff, column_ff[cprf_pkg::PAT_SIDE_BITS-1:0]};
   assign end_of_line   = (column_ff == span_width_ff);

   // Next engine state and result
   always_comb begin
      in_valid_in     = in_valid_ff;
      active_in       = active_ff;
      line_address_in = line_address_ff;
      column_in       = column_ff;
      span_width_in   = span_width_ff;
      rows_left_in    = rows_left_ff;
      pattern_row_in  = pattern_row_ff;
      held_pattern_in = held_pattern_ff;
      held_color_in   = held_color_ff;
      out_valid_in    = out_valid_ff;
      out_status_in   = out_status_ff;
      out_we_in       = out_we_ff;
      out_address_in  = out_address_ff;
      out_color_in    = out_color_ff;
      out_last_in     = out_last_ff;

      // The response register empties when its transaction is taken
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_accept) begin
         in_valid_in = 1'b1;
      end

      if (advance) begin
         out_valid_in   = 1'b1;
         out_status_in  = cprf_pkg::STATUS_OK;
         out_we_in      = 1'b0;
         out_address_in = '0;
         out_color_in   = '0;
         out_last_in    = 1'b0;
         if (in_command_ff == cprf_pkg::CMD_START) begin
            if (clip_empty) begin
               // Nothing left after clipping: reject and go idle
               out_status_in = cprf_pkg::STATUS_EMPTY;
               active_in     = 1'b0;
            end else begin
               active_in       = 1'b1;
               line_address_in = first_address;
               column_in       = '0;
               span_width_in   = span_ext[COORD_BITS-1:0];
               rows_left_in    = rows_ext[COORD_BITS-1:0];
               pattern_row_in  = '0;
               held_pattern_in = in_pattern_ff;
               held_color_in   = in_color_ff;
               out_address_in  = first_address;
               out_color_in    = in_color_ff;
            end
         end else if (!active_ff) begin
            // A step with no rectangle running leaves the state alone
            out_status_in = cprf_pkg::STATUS_IDLE_STEP;
         end else begin
            out_we_in      = held_pattern_ff[pattern_index];
            out_address_in = line_address_ff + ADDR_BITS'(column_ff);
            out_color_in   = held_color_ff;
            out_last_in    = end_of_line && (rows_left_ff == '0);
            if (end_of_line) begin
               column_in       = '0;
               line_address_in = line_address_ff + ADDR_BITS'(pitch_ff);
               pattern_row_in  = pattern_row_ff + cprf_pkg::PAT_SIDE_BITS'(1);
               if (rows_left_ff == '0) begin
                  active_in = 1'b0;
               end else begin
                  rows_left_in = rows_left_ff - COORD_BITS'(1);
               end
            end else begin
               column_in = column_ff + COORD_BITS'(1);
            end
         end
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= '0;
         pitch_ff        <= cprf_pkg::PITCH_BITS'(cprf_pkg::PITCH_RESET);
         clip_left_ff    <= '0;
         clip_top_ff     <= '0;
         clip_right_ff   <= COORD_BITS'(cprf_pkg::CLIP_RIGHT_RESET);
         clip_bottom_ff  <= COORD_BITS'(cprf_pkg::CLIP_BOTTOM_RESET);
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         active_ff       <= 1'b0;
         line_address_ff <= '0;
         column_ff       <= '0;
         span_width_ff   <= '0;
         rows_left_ff    <= '0;
         pattern_row_ff  <= '0;
         held_pattern_ff <= '0;
         held_color_ff   <= '0;
      end else begin
         frame_base_ff   <= frame_base_in;
         pitch_ff        <= pitch_in;
         clip_left_ff    <= clip_left_in;
         clip_top_ff     <= clip_top_in;
         clip_right_ff   <= clip_right_in;
         clip_bottom_ff  <= clip_bottom_in;
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         active_ff       <= active_in;
         line_address_ff <= line_address_in;
         column_ff       <= column_in;
         span_width_ff   <= span_width_in;
         rows_left_ff    <= rows_left_in;
         pattern_row_ff  <= pattern_row_in;
         held_pattern_ff <= held_pattern_in;
         held_color_ff   <= held_color_in;
      end
   end

   // Payload of the input register, loaded with each accepted transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_command_ff <= req_command;
         in_left_ff    <= req_area_left;
         in_top_ff     <= req_area_top;
         in_right_ff   <= req_area_right;
         in_bottom_ff  <= req_area_bottom;
         in_pattern_ff <= req_pattern_bits;
         in_color_ff   <= req_fill_color;
      end
   end

   // Payload of the result register
   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_we_ff      <= out_we_in;
      out_address_ff <= out_address_in;
      out_color_ff   <= out_color_in;
      out_last_ff    <= out_last_in;
   end

   // Response ports
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_write_enable  = out_we_ff;
   assign rsp_pixel_address = out_address_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_last_pixel    = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/cprf_checker.sv
// Port checker of the clipped pattern rectangle fill engine, bound to the top level.
`default_nettype none
`include "clipped_pattern_rect_fill_assert.svh"
module cprf_checker #(
   parameter int COORD_BITS = 16,
   parameter int ADDR_BITS  = 24
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [cprf_pkg::STATUS_BITS-1:0]  rsp_status,
   input wire logic                              rsp_write_enable,
   input wire logic [ADDR_BITS-1:0]              rsp_pixel_address,
   input wire logic [cprf_pkg::COLOR_BITS-1:0]   rsp_pixel_color,
   input wire logic                              rsp_last_pixel
);

   // A stalled response transaction stays and keeps its payload
   `CPRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_pixel_address) &&
      $stable(rsp_pixel_color) && $stable(rsp_write_enable) && $stable(rsp_last_pixel))

   // A rejected start or an idle step carries no pixel
   `CPRF_ASSERT_SAME(a_error_clean, clock, reset,
      rsp_valid && (rsp_status != cprf_pkg::STATUS_OK),
      !rsp_write_enable && !rsp_last_pixel && (rsp_pixel_address == '0) &&
      (rsp_pixel_color == '0))

   // The request side stalls only while a finished response is held back
   `CPRF_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Reset leaves no response pending
   `CPRF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind clipped_pattern_rect_fill cprf_checker #(
   .COORD_BITS (COORD_BITS),
   .ADDR_BITS  (ADDR_BITS)
) u_cprf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_write_enable  (rsp_write_enable),
   .rsp_pixel_address (rsp_pixel_address),
   .rsp_pixel_color   (rsp_pixel_color),
   .rsp_last_pixel    (rsp_last_pixel)
);
`default_nettype wire
